[rtl/amp_pkg.sv]
// ----------------------------------------------------------------------------
// amp_pkg
// Shared types, register map and arithmetic helpers for the alpha mask
// apply and premultiply unit.
// ----------------------------------------------------------------------------
package amp_pkg;

  localparam int unsigned DimW      = 13;
  localparam int unsigned OffW      = 14;
  localparam int unsigned ChanW     = 8;
  localparam int unsigned RegIdxW   = 3;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned DataW     = 32;
  localparam int unsigned DefMaxDim = 4096;

  typedef enum logic [RegIdxW-1:0] {
    RegImageWidth  = 3'd0,
    RegImageHeight = 3'd1,
    RegOffsetX     = 3'd2,
    RegOffsetY     = 3'd3,
    RegMaskWidth   = 3'd4,
    RegMaskHeight  = 3'd5,
    RegInvert      = 3'd6,
    RegPremultiply = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [DimW-1:0] image_width;
    logic [DimW-1:0] image_height;
    logic [OffW-1:0] mask_offset_x;
    logic [OffW-1:0] mask_offset_y;
    logic [DimW-1:0] mask_width;
    logic [DimW-1:0] mask_height;
    logic            invert_enable;
    logic            premultiply_enable;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
    logic             scale_en;
    logic             frame_end;
  } pix_t;

  // floor(x / 255) for x below 65280
  function automatic logic [ChanW-1:0] div255(input logic [2*ChanW-1:0] x);
    logic [2*ChanW:0] s;
    s = {1'b0, x} + {{(ChanW+1){1'b0}}, x[2*ChanW-1:ChanW]} + {{(2*ChanW){1'b0}}, 1'b1};
    return s[2*ChanW-1:ChanW];
  endfunction

  function automatic logic [ChanW-1:0] scale_chan(input logic [ChanW-1:0] c,
                                                  input logic [ChanW-1:0] a);
    logic [2*ChanW-1:0] p;
    p = {{ChanW{1'b0}}, c} * {{ChanW{1'b0}}, a};
    return div255(p);
  endfunction

endpackage

[rtl/amp_cfg_regs.sv]
// ----------------------------------------------------------------------------
// amp_cfg_regs
// APB-style configuration register file.
// ----------------------------------------------------------------------------
module amp_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [amp_pkg::AddrW-1:0] paddr,
  input  logic [amp_pkg::DataW-1:0] pwdata,
  output logic [amp_pkg::DataW-1:0] prdata,
  output amp_pkg::cfg_t             cfg
);

  amp_pkg::cfg_t     cfg_r;
  amp_pkg::reg_idx_t idx;
  logic              wr_en;

  assign idx   = amp_pkg::reg_idx_t'(paddr[amp_pkg::AddrW-1:2]);
  assign wr_en = psel && penable && pwrite;
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width        <= amp_pkg::DimW'(1);
      cfg_r.image_height       <= amp_pkg::DimW'(1);
      cfg_r.mask_offset_x      <= '0;
      cfg_r.mask_offset_y      <= '0;
      cfg_r.mask_width         <= '0;
      cfg_r.mask_height        <= '0;
      cfg_r.invert_enable      <= 1'b0;
      cfg_r.premultiply_enable <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        amp_pkg::RegImageWidth:  cfg_r.image_width        <= pwdata[amp_pkg::DimW-1:0];
        amp_pkg::RegImageHeight: cfg_r.image_height       <= pwdata[amp_pkg::DimW-1:0];
        amp_pkg::RegOffsetX:     cfg_r.mask_offset_x      <= pwdata[amp_pkg::OffW-1:0];
        amp_pkg::RegOffsetY:     cfg_r.mask_offset_y      <= pwdata[amp_pkg::OffW-1:0];
        amp_pkg::RegMaskWidth:   cfg_r.mask_width         <= pwdata[amp_pkg::DimW-1:0];
        amp_pkg::RegMaskHeight:  cfg_r.mask_height        <= pwdata[amp_pkg::DimW-1:0];
        amp_pkg::RegInvert:      cfg_r.invert_enable      <= pwdata[0];
        amp_pkg::RegPremultiply: cfg_r.premultiply_enable <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      amp_pkg::RegImageWidth:  prdata = {{(amp_pkg::DataW-amp_pkg::DimW){1'b0}}, cfg_r.image_width};
      amp_pkg::RegImageHeight: prdata = {{(amp_pkg::DataW-amp_pkg::DimW){1'b0}}, cfg_r.image_height};
      amp_pkg::RegOffsetX:     prdata = {{(amp_pkg::DataW-amp_pkg::OffW){1'b0}}, cfg_r.mask_offset_x};
      amp_pkg::RegOffsetY:     prdata = {{(amp_pkg::DataW-amp_pkg::OffW){1'b0}}, cfg_r.mask_offset_y};
      amp_pkg::RegMaskWidth:   prdata = {{(amp_pkg::DataW-amp_pkg::DimW){1'b0}}, cfg_r.mask_width};
      amp_pkg::RegMaskHeight:  prdata = {{(amp_pkg::DataW-amp_pkg::DimW){1'b0}}, cfg_r.mask_height};
      amp_pkg::RegInvert:      prdata = {{(amp_pkg::DataW-1){1'b0}}, cfg_r.invert_enable};
      amp_pkg::RegPremultiply: prdata = {{(amp_pkg::DataW-1){1'b0}}, cfg_r.premultiply_enable};
      default:                 prdata = '0;
    endcase
  end

endmodule

[rtl/amp_window.sv]
// ----------------------------------------------------------------------------
// amp_window
// Raster position tracking, mask window test and alpha selection; first
// pipeline register.
// ----------------------------------------------------------------------------
module amp_window #(
  parameter int unsigned MAX_DIM = amp_pkg::DefMaxDim
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  amp_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [amp_pkg::ChanW-1:0] red,
  input  logic [amp_pkg::ChanW-1:0] green,
  input  logic [amp_pkg::ChanW-1:0] blue,
  input  logic [amp_pkg::ChanW-1:0] mask_sample,
  output logic                      pix_valid,
  input  logic                      pix_ready,
  output amp_pkg::pix_t             pix
);

  localparam int unsigned CntW = $clog2(MAX_DIM);
  localparam int unsigned EffW = CntW + 1;
  localparam int unsigned ExtW = (EffW > amp_pkg::DimW) ? EffW : amp_pkg::DimW;
  localparam int unsigned SgnW = ExtW + 3;
  localparam logic signed [SgnW-1:0] SZero = '0;

  logic [CntW-1:0]        col_r, col_nxt;
  logic [CntW-1:0]        row_r, row_nxt;
  logic                   valid_r;
  amp_pkg::pix_t          pix_r, pix_nxt;
  logic                   accept;
  logic [ExtW-1:0]        w_ext, h_ext;
  logic [EffW-1:0]        w_eff, h_eff;
  logic signed [SgnW-1:0] x_lo, x_hi, y_lo, y_hi;
  logic signed [SgnW-1:0] off_x, off_y, pos_x, pos_y;
  logic                   in_win;
  logic [amp_pkg::ChanW-1:0] alpha;
  logic                   last_col, last_row;

  assign in_ready  = !valid_r || pix_ready;
  assign accept    = in_valid && in_ready;
  assign pix_valid = valid_r;
  assign pix       = pix_r;

  always_comb begin
    w_ext = {{(ExtW-amp_pkg::DimW){1'b0}}, cfg.image_width};
    h_ext = {{(ExtW-amp_pkg::DimW){1'b0}}, cfg.image_height};
    if (w_ext == '0) begin
      w_ext = ExtW'(1);
    end else if (w_ext > ExtW'(MAX_DIM)) begin
      w_ext = ExtW'(MAX_DIM);
    end
    if (h_ext == '0) begin
      h_ext = ExtW'(1);
    end else if (h_ext > ExtW'(MAX_DIM)) begin
      h_ext = ExtW'(MAX_DIM);
    end
    w_eff = w_ext[EffW-1:0];
    h_eff = h_ext[EffW-1:0];
  end

  always_comb begin
    off_x = {{(SgnW-amp_pkg::OffW){cfg.mask_offset_x[amp_pkg::OffW-1]}}, cfg.mask_offset_x};
    off_y = {{(SgnW-amp_pkg::OffW){cfg.mask_offset_y[amp_pkg::OffW-1]}}, cfg.mask_offset_y};
    pos_x = {{(SgnW-CntW){1'b0}}, col_r};
    pos_y = {{(SgnW-CntW){1'b0}}, row_r};
    x_lo  = (off_x > SZero) ? off_x : SZero;
    y_lo  = (off_y > SZero) ? off_y : SZero;
    x_hi  = off_x + {{(SgnW-amp_pkg::DimW){1'b0}}, cfg.mask_width};
    y_hi  = off_y + {{(SgnW-amp_pkg::DimW){1'b0}}, cfg.mask_height};
    if (x_hi > $signed({{(SgnW-EffW){1'b0}}, w_eff})) begin
      x_hi = {{(SgnW-EffW){1'b0}}, w_eff};
    end
    if (y_hi > $signed({{(SgnW-EffW){1'b0}}, h_eff})) begin
      y_hi = {{(SgnW-EffW){1'b0}}, h_eff};
    end
    in_win = (pos_x >= x_lo) && (pos_x < x_hi) && (pos_y >= y_lo) && (pos_y < y_hi);
  end

  always_comb begin
    alpha = '0;
    if (in_win) begin
      alpha = cfg.invert_enable ? ~mask_sample : mask_sample;
    end
    last_col = ({1'b0, col_r} + EffW'(1)) >= w_eff;
    last_row = ({1'b0, row_r} + EffW'(1)) >= h_eff;

    col_nxt = col_r + CntW'(1);
    row_nxt = row_r;
    pix_nxt.frame_end = 1'b0;
    if (last_col) begin
      col_nxt = '0;
      if (last_row) begin
        row_nxt = '0;
        pix_nxt.frame_end = 1'b1;
      end else begin
        row_nxt = row_r + CntW'(1);
      end
    end

    pix_nxt.red      = red;
    pix_nxt.green    = green;
    pix_nxt.blue     = blue;
    pix_nxt.alpha    = alpha;
    pix_nxt.scale_en = in_win && cfg.premultiply_enable && (alpha != {amp_pkg::ChanW{1'b1}});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      valid_r <= 1'b0;
    end else if (accept) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      valid_r <= 1'b1;
    end else if (pix_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

[rtl/amp_premul.sv]
// ----------------------------------------------------------------------------
// amp_premul
// Colour premultiply by alpha / 255 and result register.
// ----------------------------------------------------------------------------
module amp_premul (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      pix_valid,
  output logic                      pix_ready,
  input  amp_pkg::pix_t             pix,
  output logic                      out_valid,
  input  logic                      out_ready,
  output amp_pkg::pix_t             out_pix
);

  logic          valid_r;
  amp_pkg::pix_t res_r, res_nxt;
  logic          take;

  assign pix_ready = !valid_r || out_ready;
  assign take      = pix_valid && pix_ready;
  assign out_valid = valid_r;
  assign out_pix   = res_r;

  always_comb begin
    res_nxt = pix;
    if (pix.scale_en) begin
      res_nxt.red   = amp_pkg::scale_chan(pix.red, pix.alpha);
      res_nxt.green = amp_pkg::scale_chan(pix.green, pix.alpha);
      res_nxt.blue  = amp_pkg::scale_chan(pix.blue, pix.alpha);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

endmodule

[rtl/alpha_mask_apply_premultiply_unit.sv]
// ----------------------------------------------------------------------------
// alpha_mask_apply_premultiply_unit
// Applies an alpha mask window to a raster pixel stream, with optional
// colour premultiply.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one base pixel per transaction
//   in raster order, with the mask byte for its aligned position. The unit
//   counts column and row itself; out_frame_end marks the last pixel.
//   Output channel (out_valid/out_ready) carries one result per input.
//   APB port sets geometry and modes; write it only while the unit is idle.
//   Path: an accepted input passes the window stage register, then the
//   premultiply result register, before its result is valid.
//   Throughput: 1 pixel per cycle while out_ready is high.
//   Stall: with out_ready low both stages fill, then in_ready drops; nothing
//   is lost or repeated.
//   Reset (rst_n low, synchronous): pipeline empties, column and row return
//   to 0, registers take their reset values (1x1 image, empty mask window).
// ----------------------------------------------------------------------------
module alpha_mask_apply_premultiply_unit #(
  parameter int unsigned MAX_DIM = amp_pkg::DefMaxDim
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [amp_pkg::AddrW-1:0] paddr,
  input  logic [amp_pkg::DataW-1:0] pwdata,
  output logic [amp_pkg::DataW-1:0] prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [amp_pkg::ChanW-1:0] in_red_in,
  input  logic [amp_pkg::ChanW-1:0] in_green_in,
  input  logic [amp_pkg::ChanW-1:0] in_blue_in,
  input  logic [amp_pkg::ChanW-1:0] in_mask_sample,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [amp_pkg::ChanW-1:0] out_red_out,
  output logic [amp_pkg::ChanW-1:0] out_green_out,
  output logic [amp_pkg::ChanW-1:0] out_blue_out,
  output logic [amp_pkg::ChanW-1:0] out_alpha_out,
  output logic                      out_frame_end
);

  amp_pkg::cfg_t cfg;
  amp_pkg::pix_t pix;
  amp_pkg::pix_t res;
  logic          pix_valid;
  logic          pix_ready;

  assign pready = 1'b1;

  amp_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  amp_window #(
    .MAX_DIM (MAX_DIM)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .red         (in_red_in),
    .green       (in_green_in),
    .blue        (in_blue_in),
    .mask_sample (in_mask_sample),
    .pix_valid   (pix_valid),
    .pix_ready   (pix_ready),
    .pix         (pix)
  );

  amp_premul u_premul (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pix   (res)
  );

  assign out_red_out   = res.red;
  assign out_green_out = res.green;
  assign out_blue_out  = res.blue;
  assign out_alpha_out = res.alpha;
  assign out_frame_end = res.frame_end;

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for alpha_mask_apply_premultiply_unit. A directed table
// hits reset state, window extremes, invert, premultiply and mid-frame
// shrink. Random phases follow, each with new geometry. A scoreboard
// predicts every pixel and compares it field by field with the result stream
// under random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 7;
  localparam int ITEM_TARGET    = 1550;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int NUM_STEPS      = 50;
  localparam logic KIND_PIX     = 1'b0;
  localparam logic KIND_CFG     = 1'b1;

  typedef struct packed {
    logic [amp_pkg::ChanW-1:0] red;
    logic [amp_pkg::ChanW-1:0] green;
    logic [amp_pkg::ChanW-1:0] blue;
    logic [amp_pkg::ChanW-1:0] alpha;
    logic                      frame_end;
  } result_t;

  typedef struct packed {
    logic                      kind;
    amp_pkg::reg_idx_t         idx;
    logic [31:0]               value;
    logic [amp_pkg::ChanW-1:0] red;
    logic [amp_pkg::ChanW-1:0] green;
    logic [amp_pkg::ChanW-1:0] blue;
    logic [amp_pkg::ChanW-1:0] mask;
    logic                      typed;
    result_t                   exp_res;
  } step_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [amp_pkg::AddrW-1:0] paddr = '0;
  logic [amp_pkg::DataW-1:0] pwdata = '0;
  logic [amp_pkg::DataW-1:0] prdata;
  logic                      pready;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [amp_pkg::ChanW-1:0] in_red_in = '0;
  logic [amp_pkg::ChanW-1:0] in_green_in = '0;
  logic [amp_pkg::ChanW-1:0] in_blue_in = '0;
  logic [amp_pkg::ChanW-1:0] in_mask_sample = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [amp_pkg::ChanW-1:0] out_red_out;
  logic [amp_pkg::ChanW-1:0] out_green_out;
  logic [amp_pkg::ChanW-1:0] out_blue_out;
  logic [amp_pkg::ChanW-1:0] out_alpha_out;
  logic                      out_frame_end;

  amp_pkg::cfg_t shadow_cfg;
  int unsigned   col_pos;
  int unsigned   row_pos;
  result_t       pending_pixels[$];
  logic          item_typed = 1'b0;
  result_t       item_expected = '0;

  int in_accepted = 0;
  int pixels_sent = 0;
  int results_checked = 0;
  int frame_ends = 0;
  int fail_count = 0;
  int input_stalls = 0;
  int settings_used = 0;
  int stall_cycles = 0;
  bit send_gaps_on = 1'b1;
  bit ready_gaps_on = 1'b1;
  bit hold_request = 1'b0;

  alpha_mask_apply_premultiply_unit DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .in_mask_sample(in_mask_sample),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out),
    .out_alpha_out (out_alpha_out),
    .out_frame_end (out_frame_end)
  );

  always #(CLK_HALF) clk = ~clk;

  step_t directed_steps [0:NUM_STEPS-1] = '{
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'h00, 8'h80, 8'hff, 1'b1,
      '{8'hff, 8'h00, 8'h80, 8'h00, 1'b1}},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h00, 8'hff, 8'h01, 8'h00, 1'b1,
      '{8'h00, 8'hff, 8'h01, 8'h00, 1'b1}},
    '{KIND_CFG, amp_pkg::RegImageWidth,  32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageHeight, 32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskWidth,   32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskHeight,  32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegPremultiply, 32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
      '{8'hff, 8'hff, 8'hff, 8'hff, 1'b1}},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'h80, 8'h01, 8'h00, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hc8, 8'h64, 8'h32, 8'h80, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegInvert,      32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'hff, 8'hff, 8'h00, 1'b1,
      '{8'hff, 8'hff, 8'hff, 8'hff, 1'b1}},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{KIND_CFG, amp_pkg::RegInvert,      32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageWidth,  32'd4, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageHeight, 32'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegOffsetX,     32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegOffsetY, 32'hffff_ffff, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskWidth,   32'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskHeight,  32'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h10, 8'h20, 8'h30, 8'h40, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'hff, 8'hff, 8'h7f, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h80, 8'h80, 8'h80, 8'hfe, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h01, 8'h02, 8'h03, 8'h04, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'haa, 8'h55, 8'hcc, 8'h33, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'h00, 8'hff, 8'h01, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageWidth,  32'd2, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h12, 8'h34, 8'h56, 8'h78, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h9a, 8'hbc, 8'hde, 8'hf0, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hfe, 8'hdc, 8'hba, 8'h98, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageWidth,  32'd8191, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageHeight, 32'd8191, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegOffsetX,     32'd4096, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegOffsetY, 32'hffff_e000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskWidth,   32'd8191, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskHeight,  32'd8191, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h11, 8'h22, 8'h33, 8'h44, 1'b1,
      '{8'h11, 8'h22, 8'h33, 8'h00, 1'b0}},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1,
      '{8'hff, 8'hff, 8'hff, 8'h00, 1'b0}},
    '{KIND_CFG, amp_pkg::RegImageWidth,  32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegImageHeight, 32'd1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 1'b1}},
    '{KIND_CFG, amp_pkg::RegOffsetX, 32'hffff_f000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegOffsetY, 32'hffff_f000, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskWidth,   32'd4096, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskHeight,  32'd4097, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h80, 8'h7f, 8'h01, 8'hfe, 1'b1,
      '{8'h80, 8'h7f, 8'h01, 8'h00, 1'b1}},
    '{KIND_CFG, amp_pkg::RegOffsetX,     32'd8191, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegOffsetY,     32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_CFG, amp_pkg::RegMaskWidth,   32'd0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, '0},
    '{KIND_PIX, amp_pkg::RegImageWidth, 32'd0, 8'h5a, 8'ha5, 8'h3c, 8'hc3, 1'b1,
      '{8'h5a, 8'ha5, 8'h3c, 8'h00, 1'b1}}
  };

  function automatic int unsigned usable_dim(logic [amp_pkg::DimW-1:0] d);
    if (d == '0) return 1;
    if (d > amp_pkg::DefMaxDim) return amp_pkg::DefMaxDim;
    return 32'(d);
  endfunction

  function automatic logic in_window_span(int pos, int off, int unsigned msize,
                                          int unsigned dim);
    int lo;
    int hi;
    lo = (off > 0) ? off : 0;
    hi = off + int'(msize);
    if (hi > int'(dim)) hi = int'(dim);
    return (pos >= lo) && (pos < hi);
  endfunction

  function automatic result_t apply_mask_pixel(logic [amp_pkg::ChanW-1:0] r,
                                               logic [amp_pkg::ChanW-1:0] g,
                                               logic [amp_pkg::ChanW-1:0] b,
                                               logic [amp_pkg::ChanW-1:0] m);
    int unsigned w;
    int unsigned h;
    int          off_x;
    int          off_y;
    result_t     res;
    w = usable_dim(shadow_cfg.image_width);
    h = usable_dim(shadow_cfg.image_height);
    off_x = $signed(shadow_cfg.mask_offset_x);
    off_y = $signed(shadow_cfg.mask_offset_y);
    res = '{red: r, green: g, blue: b, alpha: 8'h00, frame_end: 1'b0};
    if (in_window_span(int'(col_pos), off_x, shadow_cfg.mask_width, w) &&
        in_window_span(int'(row_pos), off_y, shadow_cfg.mask_height, h)) begin
      res.alpha = shadow_cfg.invert_enable ? ~m : m;
      if (res.alpha != 8'hff && shadow_cfg.premultiply_enable) begin
        res.red   = 8'((int'(r) * int'(res.alpha)) / 255);
        res.green = 8'((int'(g) * int'(res.alpha)) / 255);
        res.blue  = 8'((int'(b) * int'(res.alpha)) / 255);
      end
    end
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      if (row_pos + 1 >= h) begin
        row_pos = 0;
        res.frame_end = 1'b1;
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [amp_pkg::ChanW-1:0] pick_channel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int pick_dim();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return 0;
    if (r < 10) return $urandom_range(4097, 8191);
    return $urandom_range(1, 12);
  endfunction

  task automatic cfg_write(amp_pkg::reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      amp_pkg::RegImageWidth:  shadow_cfg.image_width        = value[amp_pkg::DimW-1:0];
      amp_pkg::RegImageHeight: shadow_cfg.image_height       = value[amp_pkg::DimW-1:0];
      amp_pkg::RegOffsetX:     shadow_cfg.mask_offset_x      = value[amp_pkg::OffW-1:0];
      amp_pkg::RegOffsetY:     shadow_cfg.mask_offset_y      = value[amp_pkg::OffW-1:0];
      amp_pkg::RegMaskWidth:   shadow_cfg.mask_width         = value[amp_pkg::DimW-1:0];
      amp_pkg::RegMaskHeight:  shadow_cfg.mask_height        = value[amp_pkg::DimW-1:0];
      amp_pkg::RegInvert:      shadow_cfg.invert_enable      = value[0];
      amp_pkg::RegPremultiply: shadow_cfg.premultiply_enable = value[0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    wait (pending_pixels.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_pixel(logic [amp_pkg::ChanW-1:0] r, logic [amp_pkg::ChanW-1:0] g,
                            logic [amp_pkg::ChanW-1:0] b, logic [amp_pkg::ChanW-1:0] m,
                            logic typed, result_t exp_res);
    int gap;
    int goal;
    gap = send_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    in_mask_sample <= m;
    item_typed    = typed;
    item_expected = exp_res;
    goal = in_accepted + 1;
    wait (in_accepted >= goal);
    pixels_sent++;
    @(negedge clk);
  endtask

  // receiver side: random stalls, occasional long hold-off
  initial begin
    int ready_wait;
    ready_wait = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_ready <= 1'b1;
      end else if (ready_gaps_on && ready_wait > 0) begin
        out_ready <= 1'b0;
        ready_wait--;
      end else begin
        out_ready <= 1'b1;
        if (ready_gaps_on) ready_wait = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = '{out_red_out, out_green_out, out_blue_out, out_alpha_out, out_frame_end};
        results_checked++;
        if (got.frame_end) frame_ends++;
        if (pending_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("[%0t] unexpected result: rgba %h %h %h %h end %b", $realtime,
                     got.red, got.green, got.blue, got.alpha, got.frame_end);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"[%0t] mismatch (exp/act): red %h/%h green %h/%h blue %h/%h ",
                        "alpha %h/%h end %b/%b"}, $realtime, want.red, got.red,
                       want.green, got.green, want.blue, got.blue,
                       want.alpha, got.alpha, want.frame_end, got.frame_end);
          end
        end
      end
      if (in_valid && !in_ready) input_stalls++;
      if (in_valid && in_ready) begin
        want = apply_mask_pixel(in_red_in, in_green_in, in_blue_in, in_mask_sample);
        if (item_typed) want = item_expected;
        pending_pixels.push_back(want);
        in_accepted++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int phase;
    int w;
    int h;
    int ew;
    int eh;
    int n_items;
    step_t s;
    phase = 0;
    shadow_cfg = '{image_width: 13'd1, image_height: 13'd1, default: '0};
    col_pos = 0;
    row_pos = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_STEPS; i++) begin
      s = directed_steps[i];
      if (s.kind == KIND_CFG) begin
        wait_idle();
        cfg_write(s.idx, s.value);
        settings_used++;
      end else begin
        send_pixel(s.red, s.green, s.blue, s.mask, s.typed, s.exp_res);
      end
    end

    while (pixels_sent < ITEM_TARGET) begin
      phase++;
      wait_idle();
      w = pick_dim();
      h = pick_dim();
      ew = (w == 0) ? 1 : ((w > amp_pkg::DefMaxDim) ? amp_pkg::DefMaxDim : w);
      eh = (h == 0) ? 1 : ((h > amp_pkg::DefMaxDim) ? amp_pkg::DefMaxDim : h);
      cfg_write(amp_pkg::RegImageWidth, w);
      cfg_write(amp_pkg::RegImageHeight, h);
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(amp_pkg::RegOffsetX, int'($urandom_range(0, 16383)) - 8192);
      end else begin
        cfg_write(amp_pkg::RegOffsetX, int'($urandom_range(0, ew + 4)) - 3);
      end
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(amp_pkg::RegOffsetY, int'($urandom_range(0, 16383)) - 8192);
      end else begin
        cfg_write(amp_pkg::RegOffsetY, int'($urandom_range(0, eh + 4)) - 3);
      end
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(amp_pkg::RegMaskWidth, $urandom_range(0, 8191));
      end else begin
        cfg_write(amp_pkg::RegMaskWidth, $urandom_range(0, ew + 3));
      end
      if ($urandom_range(0, 9) == 0) begin
        cfg_write(amp_pkg::RegMaskHeight, $urandom_range(0, 8191));
      end else begin
        cfg_write(amp_pkg::RegMaskHeight, $urandom_range(0, eh + 3));
      end
      cfg_write(amp_pkg::RegInvert, $urandom_range(0, 1));
      cfg_write(amp_pkg::RegPremultiply, 32'($urandom_range(0, 3) != 0));
      settings_used++;
      send_gaps_on  = $urandom_range(0, 3) != 0;
      ready_gaps_on = $urandom_range(0, 3) != 0;
      n_items = ew * eh * 2;
      if (n_items > 120) n_items = 120;
      if (n_items < 8) n_items = 8;
      if (phase == 3 || phase == 15) begin
        hold_request = 1'b1;
        send_gaps_on = 1'b0;
        if (n_items < 24) n_items = 24;
      end
      repeat (n_items)
        send_pixel(pick_channel(), pick_channel(), pick_channel(), pick_channel(), 1'b0, '0);
    end

    wait_idle();
    repeat (10) @(negedge clk);
    fail_count += pending_pixels.size();
    $display("Covered %0d pixels under %0d settings: %0d results checked, %0d frame ends,",
             pixels_sent, settings_used, results_checked, frame_ends);
    $display("%0d input back-pressure cycles, %0d failures", input_stalls, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
